### rtl/four_digit_seven_segment_counter_defines.svh
// Assertion macros shared by the checker of the seven-segment counter
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_COUNTER_DEFINES_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_COUNTER_DEFINES_SVH

// same-cycle implication, off during reset
`define FDSC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdsc assertion failed");

// next-cycle implication, off during reset
`define FDSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdsc assertion failed");

// next-cycle implication, checked in reset too
`define FDSC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fdsc assertion failed");

`endif

### rtl/fdsc_pkg.sv
// Package: shared widths, constants and result type of the seven-segment counter
`default_nettype none

package fdsc_pkg;

  localparam int unsigned POSITION_COUNT  = 4;
  localparam int unsigned POSITION_WIDTH  = 2;
  localparam int unsigned SEGMENT_WIDTH   = 7;
  localparam int unsigned BCD_WIDTH       = 4;
  localparam int unsigned ROUNDS_WIDTH    = 8;
  localparam int unsigned DIGIT_COUNT_DEF = 4;

  localparam logic [ROUNDS_WIDTH-1:0] ROUNDS_RESET = 8'd10;

  typedef struct packed {
    logic [POSITION_COUNT-1:0] enable_n;
    logic [SEGMENT_WIDTH-1:0]  segments;
    logic [POSITION_WIDTH-1:0] position;
  } fdsc_result_t;

endpackage

`default_nettype wire

### rtl/four_digit_seven_segment_counter.sv
// Top level: multiplexed four-digit seven-segment display counter
//
// Input channel (in_valid, in_stall, clear_pressed): one request per display
// slot tick. A request is taken at a clock edge with in_valid high and
// in_stall low. clear_pressed zeroes the count when the slot is digit 0.
// Output channel (out_valid, out_stall): one result per request, carrying
// digit_enable_n (active low, bit 0 thousands), segment_pattern (a in bit 0)
// and digit_position. Results leave in request order.
// A result is registered at the output, or in the skid entry under out_stall.
// Throughput is one request per cycle while in_stall is low; the core state
// update and the digit decode finish in the cycle the request is taken.
// When out_stall holds a result, one further request lands in a skid entry;
// in_stall rises only while that entry is occupied.
// rounds_write loads rounds_data into the rounds-per-increment register
// (0 acts as 1); write it only while the block is idle.
// Synchronous reset clears the count, scan position and round counter,
// empties both result stages and sets rounds-per-increment to 10.
`default_nettype none

module four_digit_seven_segment_counter
  import fdsc_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      clear_pressed,
  input  wire logic                      rounds_write,
  input  wire logic [ROUNDS_WIDTH-1:0]   rounds_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [POSITION_COUNT-1:0]      digit_enable_n,
  output logic [SEGMENT_WIDTH-1:0]       segment_pattern,
  output logic [POSITION_WIDTH-1:0]      digit_position
);

  fdsc_result_t core_result;
  fdsc_result_t out_data;
  logic         full;
  logic         fire;

  assign in_stall = full;
  assign fire     = in_valid && !full;

  fdsc_core #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .clear_pressed (clear_pressed),
    .rounds_write  (rounds_write),
    .rounds_data   (rounds_data),
    .result        (core_result)
  );

  fdsc_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (core_result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign digit_enable_n  = out_data.enable_n;
  assign segment_pattern = out_data.segments;
  assign digit_position  = out_data.position;

endmodule

`default_nettype wire

### rtl/fdsc_core.sv
// Counter state, scan sequencing and digit decode for one display slot per request
`default_nettype none

module fdsc_core
  import fdsc_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    fire,
  input  wire logic                    clear_pressed,
  input  wire logic                    rounds_write,
  input  wire logic [ROUNDS_WIDTH-1:0] rounds_data,
  output fdsc_result_t                 result
);

  localparam int unsigned LAST_POSITION =
    (DIGIT_COUNT < 1) ? 0 :
    ((DIGIT_COUNT > POSITION_COUNT) ? POSITION_COUNT - 1 : DIGIT_COUNT - 1);

  typedef logic [BCD_WIDTH-1:0] bcd_t;

  bcd_t                      digits      [POSITION_COUNT];
  bcd_t                      digits_next [POSITION_COUNT];
  bcd_t                      cleared     [POSITION_COUNT];
  bcd_t                      bumped      [POSITION_COUNT];
  logic [POSITION_WIDTH-1:0] scan_position;
  logic [POSITION_WIDTH-1:0] scan_position_next;
  logic [ROUNDS_WIDTH-1:0]   round_counter;
  logic [ROUNDS_WIDTH-1:0]   round_counter_next;
  logic [ROUNDS_WIDTH-1:0]   rounds_per_increment;
  logic [ROUNDS_WIDTH-1:0]   limit;
  logic [ROUNDS_WIDTH:0]     round_plus;
  logic                      carry;
  bcd_t                      digit;

  function automatic logic [SEGMENT_WIDTH-1:0] seg_decode(input bcd_t d);
    logic [SEGMENT_WIDTH-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

  always_comb begin
    for (int i = 0; i < POSITION_COUNT; i++) begin
      cleared[i] = (scan_position == '0 && clear_pressed) ? '0 : digits[i];
    end

    // decimal increment, units at the highest index, wraps 9999 to 0
    carry = 1'b1;
    for (int i = POSITION_COUNT - 1; i >= 0; i--) begin
      if (carry && cleared[i] == bcd_t'(9)) begin
        bumped[i] = '0;
      end else begin
        bumped[i] = cleared[i] + bcd_t'(carry);
        carry     = 1'b0;
      end
    end

    digit = cleared[scan_position];
    result.enable_n = ~(POSITION_COUNT'(1) << scan_position);
    result.segments = seg_decode(digit);
    result.position = scan_position;

    limit      = (rounds_per_increment == '0) ? ROUNDS_WIDTH'(1) : rounds_per_increment;
    round_plus = {1'b0, round_counter} + (ROUNDS_WIDTH + 1)'(1);

    digits_next        = cleared;
    round_counter_next = round_counter;
    if (scan_position >= POSITION_WIDTH'(LAST_POSITION)) begin
      scan_position_next = '0;
      if (round_plus >= {1'b0, limit}) begin
        round_counter_next = '0;
        digits_next        = bumped;
      end else begin
        round_counter_next = round_plus[ROUNDS_WIDTH-1:0];
      end
    end else begin
      scan_position_next = scan_position + POSITION_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POSITION_COUNT; i++) begin
        digits[i] <= '0;
      end
      scan_position        <= '0;
      round_counter        <= '0;
      rounds_per_increment <= ROUNDS_RESET;
    end else begin
      if (fire) begin
        digits        <= digits_next;
        scan_position <= scan_position_next;
        round_counter <= round_counter_next;
      end
      if (rounds_write) begin
        rounds_per_increment <= rounds_data;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/fdsc_out_buffer.sv
// Result register with one skid entry between the core and the output channel
`default_nettype none

module fdsc_out_buffer
  import fdsc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  fdsc_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  wire logic   out_stall,
  output fdsc_result_t out_data
);

  fdsc_result_t skid_data;
  logic         skid_valid;
  logic         pop;

  assign full = skid_valid;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/fdsc_checker.sv
// Port checker for the seven-segment counter, bound to the top level
`default_nettype none
`include "four_digit_seven_segment_counter_defines.svh"

module fdsc_checker
  import fdsc_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [POSITION_COUNT-1:0] digit_enable_n,
  input wire logic [SEGMENT_WIDTH-1:0]  segment_pattern,
  input wire logic [POSITION_WIDTH-1:0] digit_position
);

  logic [POSITION_COUNT+SEGMENT_WIDTH+POSITION_WIDTH-1:0] out_word;
  logic [POSITION_COUNT-1:0]                              enable_want;

  assign out_word    = {digit_enable_n, segment_pattern, digit_position};
  assign enable_want = ~(POSITION_COUNT'(1) << digit_position);

  `FDSC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))
  `FDSC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid && !in_stall)
  `FDSC_ASSERT_NOW(a_skid_needs_out, clk, rst, in_stall, out_valid)
  `FDSC_ASSERT_NOW(a_enable_decode, clk, rst, out_valid, digit_enable_n == enable_want)

endmodule

bind four_digit_seven_segment_counter fdsc_checker u_fdsc_checker (.*);

`default_nettype wire

### tb/segment_scan_checker.sv
// Checker that predicts each display slot of the seven-segment counter and compares results
module segment_scan_checker
  import fdsc_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      clear_pressed,
  input  logic                      rounds_write,
  input  logic [ROUNDS_WIDTH-1:0]   rounds_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [POSITION_COUNT-1:0] digit_enable_n,
  input  logic [SEGMENT_WIDTH-1:0]  segment_pattern,
  input  logic [POSITION_WIDTH-1:0] digit_position,
  output int                        pending,
  output int                        errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_WRAP = 10000;
  localparam int unsigned LAST_POSITION =
    (DIGIT_COUNT < 1) ? 0 : (DIGIT_COUNT > POSITION_COUNT) ? POSITION_COUNT - 1 : DIGIT_COUNT - 1;

  logic [13:0]               count_now;
  logic [POSITION_WIDTH-1:0] scan_now;
  logic [ROUNDS_WIDTH-1:0]   rounds_done;
  logic [ROUNDS_WIDTH-1:0]   rounds_per_step;
  fdsc_result_t              slots_due[$];

  function automatic logic [SEGMENT_WIDTH-1:0] segments_of(input int unsigned digit);
    case (digit)
      0: return 7'h3F;
      1: return 7'h06;
      2: return 7'h5B;
      3: return 7'h4F;
      4: return 7'h66;
      5: return 7'h6D;
      6: return 7'h7D;
      7: return 7'h07;
      8: return 7'h7F;
      default: return 7'h6F;
    endcase
  endfunction

  function automatic int unsigned place_of(input logic [POSITION_WIDTH-1:0] pos);
    case (pos)
      2'd0: return 1000;
      2'd1: return 100;
      2'd2: return 10;
      default: return 1;
    endcase
  endfunction

  function automatic fdsc_result_t next_slot(input logic clear);
    fdsc_result_t slot;
    int unsigned  digit;
    int unsigned  limit;
    if (scan_now == '0 && clear) begin
      count_now = '0;
    end
    digit = (int'(count_now) / place_of(scan_now)) % 10;
    slot.enable_n = ~(4'b0001 << scan_now);
    slot.segments = segments_of(digit);
    slot.position = scan_now;
    if (scan_now >= LAST_POSITION) begin
      scan_now = '0;
      limit = (rounds_per_step == '0) ? 1 : rounds_per_step;
      if (int'(rounds_done) + 1 >= limit) begin
        rounds_done = '0;
        count_now = (int'(count_now) + 1 >= COUNT_WRAP) ? '0 : count_now + 1'b1;
      end else begin
        rounds_done = rounds_done + 1'b1;
      end
    end else begin
      scan_now = scan_now + 1'b1;
    end
    return slot;
  endfunction

  always @(posedge clk) begin : compare
    fdsc_result_t want;
    int           bad;
    bad = 0;
    if (rst) begin
      count_now = '0;
      scan_now = '0;
      rounds_done = '0;
      rounds_per_step = ROUNDS_RESET;
      slots_due.delete();
      pending <= 0;
    end else begin
      if (rounds_write) begin
        rounds_per_step = rounds_data;
      end
      if (out_valid && !out_stall) begin
        if (slots_due.size() == 0) begin
          $error("display slot result with no request waiting");
          bad++;
        end else begin
          want = slots_due.pop_front();
          if (digit_enable_n !== want.enable_n) begin
            $error("digit_enable_n: expected %b, got %b", want.enable_n, digit_enable_n);
            bad++;
          end
          if (segment_pattern !== want.segments) begin
            $error("segment_pattern: expected %b, got %b", want.segments, segment_pattern);
            bad++;
          end
          if (digit_position !== want.position) begin
            $error("digit_position: expected %0d, got %0d", want.position, digit_position);
            bad++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        slots_due.push_back(next_slot(clear_pressed));
      end
      pending <= slots_due.size();
      errors <= errors + bad;
    end
  end

endmodule

### tb/tb_four_digit_seven_segment_counter.sv
// Testbench top for the seven-segment counter: clock, reset, stimulus and verdict
module tb_four_digit_seven_segment_counter;
  import fdsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_TICKS = 1150;
  localparam int FINAL_TICKS  = 150;
  localparam int LONG_HOLD    = 40;
  localparam int STUCK_LIMIT  = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic clear_pressed = 1'b0;
  logic rounds_write = 1'b0;
  logic [ROUNDS_WIDTH-1:0] rounds_data = '0;
  logic out_stall = 1'b0;
  logic quiet = 1'b0;
  logic hold_now = 1'b0;

  logic                      in_stall;
  logic                      out_valid;
  logic [POSITION_COUNT-1:0] digit_enable_n;
  logic [SEGMENT_WIDTH-1:0]  segment_pattern;
  logic [POSITION_WIDTH-1:0] digit_position;

  int pending;
  int errors;
  int sent;

  four_digit_seven_segment_counter dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .clear_pressed   (clear_pressed),
    .rounds_write    (rounds_write),
    .rounds_data     (rounds_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .digit_enable_n  (digit_enable_n),
    .segment_pattern (segment_pattern),
    .digit_position  (digit_position)
  );

  segment_scan_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .clear_pressed   (clear_pressed),
    .rounds_write    (rounds_write),
    .rounds_data     (rounds_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .digit_enable_n  (digit_enable_n),
    .segment_pattern (segment_pattern),
    .digit_position  (digit_position),
    .pending         (pending),
    .errors          (errors)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_tick(input logic clear);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    clear_pressed <= clear;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_round(input logic [POSITION_COUNT-1:0] clears);
    for (int p = 0; p < POSITION_COUNT; p++) begin
      send_tick(clears[p]);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_rounds(input logic [ROUNDS_WIDTH-1:0] value);
    settle();
    rounds_write <= 1'b1;
    rounds_data <= value;
    @(negedge clk);
    rounds_write <= 1'b0;
  endtask

  function automatic logic [ROUNDS_WIDTH-1:0] pick_rounds();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 8'd1;
      2: return 8'hFF;
      3: return ROUNDS_WIDTH'($urandom);
      default: return ROUNDS_WIDTH'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_now && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset rounds value, clear at position 0 only
    send_round(4'b0001);
    // zero register acts as one, lowered below progress
    write_rounds('0);
    send_round(4'b0000);
    send_round(4'b0000);
    // clear ignored away from position 0
    send_round(4'b1110);
    // clear with a round pending
    write_rounds(8'd4);
    send_round(4'b0000);
    send_round(4'b0001);

    // advance the count across the tens and hundreds carries
    write_rounds(8'd1);
    repeat (POSITION_COUNT * 120) send_tick(1'b0);

    sent = 0;
    write_rounds(8'd3);
    hold_now <= 1'b1;
    repeat (60) send_tick($urandom_range(0, 23) == 0);
    while (sent < RANDOM_TICKS) begin
      write_rounds(pick_rounds());
      quiet <= ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(8, 120)) send_tick($urandom_range(0, 23) == 0);
    end

    write_rounds(ROUNDS_WIDTH'($urandom_range(1, 6)));
    quiet <= 1'b1;
    repeat (FINAL_TICKS) send_tick($urandom_range(0, 23) == 0);

    settle();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### four_digit_seven_segment_counter.f
+incdir+rtl
rtl/fdsc_pkg.sv
rtl/fdsc_core.sv
rtl/fdsc_out_buffer.sv
rtl/four_digit_seven_segment_counter.sv
rtl/fdsc_checker.sv
tb/segment_scan_checker.sv
tb/tb_four_digit_seven_segment_counter.sv
